// File: sv/onewire_eprom_slave_macros.svh
// Assertion macros shared by the one-wire EPROM slave.
// No dependencies; included by the top level only.
`ifndef ONEWIRE_EPROM_SLAVE_MACROS_SVH
`define ONEWIRE_EPROM_SLAVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OWEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("onewire_eprom_slave: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OWEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("onewire_eprom_slave: next-cycle check failed");

`endif

// File: sv/owep_pkg.sv
// Shared types, codes and the CRC16 byte update for the one-wire EPROM slave.
// No dependencies; used by owep_ctrl, owep_dp and onewire_eprom_slave.
package owep_pkg;

    // ROM/memory function command bytes
    localparam logic [7:0] CMD_READ_MEM      = 8'hF0;
    localparam logic [7:0] CMD_EXT_READ      = 8'hA5;
    localparam logic [7:0] CMD_READ_STATUS   = 8'hAA;
    localparam logic [7:0] CMD_WRITE_MEM     = 8'h0F;
    localparam logic [7:0] CMD_SPEED_WR_MEM  = 8'hF3;
    localparam logic [7:0] CMD_WRITE_STATUS  = 8'h55;
    localparam logic [7:0] CMD_SPEED_WR_STAT = 8'hF5;

    // Slot kinds on the request side
    localparam logic [1:0] SLOT_RESET = 2'd0;
    localparam logic [1:0] SLOT_WRITE = 2'd1;
    localparam logic [1:0] SLOT_READ  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_TURN    = 2'd2;

    localparam int unsigned PAGE_BYTES = 32;
    localparam logic [15:0] ST_END     = 16'h0200;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_CLEAR,
        STEP_LATCH,
        STEP_PROT,
        STEP_TGT,
        STEP_EXEC
    } step_t;

    typedef struct packed {
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic       out_valid;
        logic [7:0] out_byte;
    } result_t;

    // Device size in bytes per size_select code
    function automatic logic [15:0] dev_size(input logic [1:0] sel);
        logic [15:0] s;
        unique case (sel)
            2'd0:    s = 16'd256;
            2'd1:    s = 16'd512;
            2'd2:    s = 16'd2048;
            default: s = 16'd8192;
        endcase
        return s;
    endfunction

    // CRC16, reflected poly 0xA001, one byte LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        logic [7:0]  v;
        logic        mix;
        x = c;
        v = b;
        for (int i = 0; i < 8; i++) begin
            mix = x[0] ^ v[0];
            x = x >> 1;
            if (mix) begin
                x = x ^ 16'hA001;
            end
            v = v >> 1;
        end
        return x;
    endfunction

endpackage

// File: sv/owep_ctrl.sv
// Step sequencer for the one-wire EPROM slave: clearing sweep, request
// accept, protection and target fetches, commit. Depends on owep_pkg.
module owep_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 out_free,
    output logic                 out_load,
    input  owep_pkg::dp_status_t status,
    output owep_pkg::dp_cmd_t    cmd
);
    import owep_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROT,
        ST_TGT,
        ST_EXEC
    } state_t;

    state_t state_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.step = STEP_NONE;
        out_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.step = STEP_CLEAR;
            ST_IDLE:  if (s_tvalid) cmd.step = STEP_LATCH;
            ST_PROT:  cmd.step = STEP_PROT;
            ST_TGT:   cmd.step = STEP_TGT;
            ST_EXEC: begin
                if (out_free) begin
                    cmd.step = STEP_EXEC;
                    out_load = 1'b1;
                end
            end
            default:  cmd.step = STEP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            unique case (state_reg)
                ST_CLEAR: if (status.clear_last) state_reg <= ST_IDLE;
                ST_IDLE:  if (s_tvalid) state_reg <= ST_PROT;
                ST_PROT:  state_reg <= ST_TGT;
                ST_TGT:   state_reg <= ST_EXEC;
                ST_EXEC:  if (out_free) state_reg <= ST_IDLE;
                default:  state_reg <= ST_CLEAR;
            endcase
        end
    end

endmodule

// File: sv/owep_dp.sv
// Datapath of the one-wire EPROM slave: data and status stores, protocol
// phase, address, CRC and result logic. Depends on owep_pkg.
module owep_dp #(
    parameter int unsigned MEM_BYTES      = 8192,
    parameter int unsigned REDIRECT_PAGES = 256,
    parameter int unsigned BITMAP_BYTES   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  owep_pkg::dp_cmd_t    cmd,
    output owep_pkg::dp_status_t status,
    input  logic [1:0]           in_slot,
    input  logic [7:0]           in_byte,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    output owep_pkg::result_t    result
);
    import owep_pkg::*;

    localparam int unsigned SD    = 3 * BITMAP_BYTES + REDIRECT_PAGES;
    localparam int unsigned MAW   = $clog2(MEM_BYTES);
    localparam int unsigned SIW   = $clog2(SD);
    localparam int unsigned CLR_N = (MEM_BYTES > SD) ? MEM_BYTES : SD;
    localparam int unsigned CW    = $clog2(CLR_N);

    localparam logic [SIW-1:0] BASE_WPR   = SIW'(BITMAP_BYTES);
    localparam logic [SIW-1:0] BASE_USED  = SIW'(2 * BITMAP_BYTES);
    localparam logic [SIW-1:0] BASE_REDIR = SIW'(3 * BITMAP_BYTES);
    localparam logic [5:0]     NSEG       = 6'(BITMAP_BYTES);
    localparam logic [8:0]     NPAGE      = 9'(REDIRECT_PAGES);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ADDR_LO, PH_ADDR_HI, PH_DONE,
        PH_RD_DATA, PH_RD_CRC_LO, PH_RD_CRC_HI,
        PH_EX_REDIR, PH_EX_RCRC_LO, PH_EX_RCRC_HI,
        PH_EX_DATA, PH_EX_DCRC_LO, PH_EX_DCRC_HI,
        PH_ST_DATA, PH_ST_CRC_LO, PH_ST_CRC_HI,
        PH_WR_DATA, PH_WR_CRC_LO, PH_WR_CRC_HI, PH_WR_RESULT
    } phase_t;

    logic [7:0] dmem [MEM_BYTES];
    logic [7:0] smem [SD];

    phase_t      phase_reg, phase_next;
    logic [7:0]  act_reg, act_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  size_sel_reg;
    logic [CW-1:0] clr_cnt_reg;

    logic [1:0]  slot_reg;
    logic [7:0]  byte_reg;
    logic        redir_ok_reg;
    logic [7:0]  redir_val_reg;
    logic [15:0] d_reg;
    logic        prot_ok_reg;
    logic [7:0]  prot_q;
    logic [7:0]  smem_q;
    logic [7:0]  dmem_q;

    // Address forms
    logic [7:0]  page;
    logic [7:0]  redir_val;
    logic [15:0] d16;
    logic        is_mem;
    logic        sends_crc;
    logic [15:0] size;

    assign page      = addr_reg[12:5];
    assign redir_val = redir_ok_reg ? ~smem_q : 8'h00;
    assign d16       = (redir_val == 8'h00) ? addr_reg : {3'b000, redir_val, addr_reg[4:0]};
    assign is_mem    = (act_reg == CMD_WRITE_MEM) || (act_reg == CMD_SPEED_WR_MEM);
    assign sends_crc = (act_reg == CMD_WRITE_MEM) || (act_reg == CMD_WRITE_STATUS);
    assign size      = dev_size(size_sel_reg);

    // Status space decode of the target address
    logic           st_valid;
    logic [SIW-1:0] st_idx;
    logic [7:0]     st_fixed;
    logic           st_is_redir;

    always_comb begin
        st_valid    = 1'b0;
        st_idx      = '0;
        st_fixed    = 8'hFF;
        st_is_redir = 1'b0;
        priority if (addr_reg < 16'h0020) begin
            st_fixed = 8'h00;
            st_valid = {1'b0, addr_reg[4:0]} < NSEG;
            st_idx   = SIW'(addr_reg[4:0]);
        end else if (addr_reg < 16'h0040) begin
            st_fixed = 8'h00;
            st_valid = {1'b0, addr_reg[4:0]} < NSEG;
            st_idx   = BASE_WPR + SIW'(addr_reg[4:0]);
        end else if (addr_reg < 16'h0060) begin
            st_fixed = 8'h00;
            st_valid = {1'b0, addr_reg[4:0]} < NSEG;
            st_idx   = BASE_USED + SIW'(addr_reg[4:0]);
        end else if (addr_reg < 16'h0100) begin
            st_fixed = 8'hFF;
        end else if (addr_reg < ST_END) begin
            st_is_redir = 1'b1;
            st_valid    = {1'b0, addr_reg[7:0]} < NPAGE;
            st_idx      = BASE_REDIR + SIW'(addr_reg[7:0]);
        end else begin
            st_fixed = 8'hFF;
        end
    end

    // Store read addresses per step
    logic           smem_re;
    logic [SIW-1:0] smem_raddr;
    logic [4:0]     seg16;
    logic [4:0]     segd;
    logic [2:0]     bitd;

    assign seg16 = d16[12:8];
    assign segd  = d_reg[12:8];
    assign bitd  = d_reg[7:5];

    always_comb begin
        smem_re    = 1'b0;
        smem_raddr = '0;
        unique case (cmd.step)
            STEP_LATCH: begin
                smem_re    = 1'b1;
                smem_raddr = BASE_REDIR + SIW'(page);
            end
            STEP_PROT: begin
                smem_re    = 1'b1;
                smem_raddr = is_mem ? SIW'(seg16) : BASE_WPR + SIW'(addr_reg[7:3]);
            end
            STEP_TGT: begin
                smem_re    = 1'b1;
                smem_raddr = is_mem ? BASE_USED + SIW'(segd) : st_idx;
            end
            default: smem_re = 1'b0;
        endcase
    end

    // Write evaluation
    logic       d_in;
    logic [7:0] mem_rd_val;
    logic       mw_prot;
    logic [7:0] mw_new;
    logic [7:0] used_new;
    logic       sw_prot;
    logic [7:0] sw_val;
    logic       sw_we;
    logic [7:0] st_rd_val;

    assign d_in       = d_reg < 16'(MEM_BYTES);
    assign mem_rd_val = d_in ? dmem_q : 8'h00;
    assign mw_prot    = !d_in || !prot_ok_reg || !prot_q[bitd];
    assign mw_new     = dmem_q & held_reg;
    assign used_new   = smem_q & ~(8'h01 << bitd);
    assign sw_prot    = st_is_redir && (!prot_ok_reg || !prot_q[addr_reg[2:0]]);
    assign sw_we      = st_valid && !sw_prot;
    assign sw_val     = !st_valid ? st_fixed : (sw_prot ? 8'h00 : smem_q & held_reg);
    assign st_rd_val  = st_valid ? smem_q : st_fixed;

    // Protocol step
    logic [15:0] inv;
    logic [15:0] addr_inc;
    logic [7:0]  v;
    logic        wr_mem_en;
    logic        wr_stat_en;
    result_t     res;

    assign inv      = ~crc_reg;
    assign addr_inc = addr_reg + 16'd1;

    always_comb begin
        logic [15:0] ta;
        phase_next = phase_reg;
        act_next   = act_reg;
        addr_next  = addr_reg;
        crc_next   = crc_reg;
        held_next  = held_reg;
        v          = 8'hFF;
        wr_mem_en  = 1'b0;
        wr_stat_en = 1'b0;
        res.out_byte   = 8'hFF;
        res.out_valid  = 1'b0;
        res.error_code = ERR_NONE;
        ta = {byte_reg, addr_reg[7:0]};
        unique case (slot_reg)
            SLOT_RESET: phase_next = PH_IDLE;
            SLOT_WRITE: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        act_next   = byte_reg;
                        crc_next   = crc_byte(16'h0000, byte_reg);
                        phase_next = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        addr_next  = {8'h00, byte_reg};
                        crc_next   = crc_byte(crc_reg, byte_reg);
                        phase_next = PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        addr_next = ta;
                        crc_next  = crc_byte(crc_reg, byte_reg);
                        unique case (act_reg)
                            CMD_READ_MEM:
                                phase_next = (ta < size) ? PH_RD_DATA : PH_RD_CRC_LO;
                            CMD_EXT_READ:
                                phase_next = (ta < size) ? PH_EX_REDIR : PH_DONE;
                            CMD_READ_STATUS:
                                phase_next = (ta < ST_END) ? PH_ST_DATA : PH_DONE;
                            CMD_WRITE_MEM, CMD_SPEED_WR_MEM:
                                phase_next = (ta < size) ? PH_WR_DATA : PH_DONE;
                            CMD_WRITE_STATUS, CMD_SPEED_WR_STAT:
                                phase_next = (ta < ST_END) ? PH_WR_DATA : PH_DONE;
                            default: begin
                                phase_next     = PH_DONE;
                                res.error_code = ERR_UNKNOWN;
                            end
                        endcase
                    end
                    PH_DONE: phase_next = PH_DONE;
                    PH_WR_DATA: begin
                        held_next = byte_reg;
                        if (act_reg != CMD_SPEED_WR_MEM) crc_next = crc_byte(crc_reg, byte_reg);
                        phase_next = sends_crc ? PH_WR_CRC_LO : PH_WR_RESULT;
                    end
                    default: res.error_code = ERR_TURN;
                endcase
            end
            SLOT_READ: begin
                res.out_valid = 1'b1;
                unique case (phase_reg)
                    PH_RD_DATA: begin
                        v         = mem_rd_val;
                        crc_next  = crc_byte(crc_reg, v);
                        addr_next = addr_inc;
                        if (addr_inc >= size) phase_next = PH_RD_CRC_LO;
                    end
                    PH_RD_CRC_LO: begin v = inv[7:0];  phase_next = PH_RD_CRC_HI; end
                    PH_RD_CRC_HI: begin v = inv[15:8]; phase_next = PH_DONE; end
                    PH_EX_REDIR: begin
                        v          = redir_val_reg;
                        crc_next   = crc_byte(crc_reg, v);
                        phase_next = PH_EX_RCRC_LO;
                    end
                    PH_EX_RCRC_LO: begin v = inv[7:0]; phase_next = PH_EX_RCRC_HI; end
                    PH_EX_RCRC_HI: begin
                        v          = inv[15:8];
                        crc_next   = 16'h0000;
                        phase_next = PH_EX_DATA;
                    end
                    PH_EX_DATA: begin
                        v         = mem_rd_val;
                        crc_next  = crc_byte(crc_reg, v);
                        addr_next = addr_inc;
                        if (addr_inc[4:0] == 5'd0) phase_next = PH_EX_DCRC_LO;
                    end
                    PH_EX_DCRC_LO: begin v = inv[7:0]; phase_next = PH_EX_DCRC_HI; end
                    PH_EX_DCRC_HI: begin
                        v          = inv[15:8];
                        crc_next   = 16'h0000;
                        phase_next = (addr_reg < size) ? PH_EX_REDIR : PH_DONE;
                    end
                    PH_ST_DATA: begin
                        v         = st_rd_val;
                        crc_next  = crc_byte(crc_reg, v);
                        addr_next = addr_inc;
                        if (addr_inc[2:0] == 3'd0) phase_next = PH_ST_CRC_LO;
                    end
                    PH_ST_CRC_LO: begin v = inv[7:0]; phase_next = PH_ST_CRC_HI; end
                    PH_ST_CRC_HI: begin
                        v          = inv[15:8];
                        crc_next   = 16'h0000;
                        phase_next = (addr_reg < ST_END) ? PH_ST_DATA : PH_DONE;
                    end
                    PH_WR_CRC_LO: begin v = inv[7:0];  phase_next = PH_WR_CRC_HI; end
                    PH_WR_CRC_HI: begin v = inv[15:8]; phase_next = PH_WR_RESULT; end
                    PH_WR_RESULT: begin
                        if (is_mem) begin
                            v         = mw_prot ? 8'h00 : mw_new;
                            wr_mem_en = !mw_prot;
                        end else begin
                            v          = sw_val;
                            wr_stat_en = sw_we;
                        end
                        addr_next = addr_inc;
                        if (sends_crc) crc_next = addr_inc;
                        phase_next = (addr_inc < (is_mem ? size : ST_END)) ? PH_WR_DATA : PH_DONE;
                    end
                    PH_DONE: res.out_valid = 1'b0;
                    default: begin
                        res.out_valid  = 1'b0;
                        res.error_code = ERR_TURN;
                    end
                endcase
                if (res.out_valid) res.out_byte = v;
            end
            default: res.error_code = ERR_TURN;
        endcase
    end

    assign result = res;

    // Store writes: clearing sweep or commit
    logic           commit;
    logic           clearing;
    logic           dmem_we;
    logic [MAW-1:0] dmem_waddr;
    logic [7:0]     dmem_wdata;
    logic           smem_we;
    logic [SIW-1:0] smem_waddr;
    logic [7:0]     smem_wdata;

    assign commit   = (cmd.step == STEP_EXEC);
    assign clearing = (cmd.step == STEP_CLEAR);

    always_comb begin
        dmem_we    = 1'b0;
        dmem_waddr = d_reg[MAW-1:0];
        dmem_wdata = mw_new;
        smem_we    = 1'b0;
        smem_waddr = is_mem ? BASE_USED + SIW'(segd) : st_idx;
        smem_wdata = is_mem ? used_new : sw_val;
        if (clearing) begin
            dmem_we    = 32'(clr_cnt_reg) < MEM_BYTES;
            dmem_waddr = MAW'(clr_cnt_reg);
            dmem_wdata = 8'hFF;
            smem_we    = 32'(clr_cnt_reg) < SD;
            smem_waddr = SIW'(clr_cnt_reg);
            smem_wdata = 8'hFF;
        end else if (commit) begin
            dmem_we = wr_mem_en;
            smem_we = wr_mem_en || wr_stat_en;
        end
    end

    assign status.clear_last = (clr_cnt_reg == CW'(CLR_N - 1));

    always_ff @(posedge aclk) begin
        if (dmem_we) dmem[dmem_waddr] <= dmem_wdata;
        if (cmd.step == STEP_PROT) dmem_q <= dmem[d16[MAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (smem_we) smem[smem_waddr] <= smem_wdata;
        if (smem_re) smem_q <= smem[smem_raddr];
    end

    // Fetch-step payload registers
    always_ff @(posedge aclk) begin
        if (cmd.step == STEP_LATCH) begin
            slot_reg     <= in_slot;
            byte_reg     <= in_byte;
            redir_ok_reg <= {1'b0, page} < NPAGE;
        end
        if (cmd.step == STEP_PROT) begin
            d_reg         <= d16;
            redir_val_reg <= redir_val;
            prot_ok_reg   <= is_mem ? ({1'b0, seg16} < NSEG) : ({1'b0, addr_reg[7:3]} < NSEG);
        end
        if (cmd.step == STEP_TGT) prot_q <= smem_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            act_reg      <= '0;
            addr_reg     <= '0;
            crc_reg      <= '0;
            held_reg     <= '0;
            size_sel_reg <= 2'd3;
            clr_cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) size_sel_reg <= cfg_wr_data;
            if (clearing && !status.clear_last) clr_cnt_reg <= clr_cnt_reg + CW'(1);
            if (commit) begin
                phase_reg <= phase_next;
                act_reg   <= act_next;
                addr_reg  <= addr_next;
                crc_reg   <= crc_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

// File: sv/onewire_eprom_slave.sv
// Top level of the one-wire EPROM slave: sequencer, datapath, result register.
// Depends on owep_pkg, owep_ctrl, owep_dp and onewire_eprom_slave_macros.svh.
//
// Byte-level slave for a one-wire add-only EPROM with 32-byte pages and
// per-page redirection. Each request is one bus slot: a bus reset, a byte
// written by the master, or a read slot; each request yields exactly one
// result (driven byte, driven flag, error code). A request goes from accept
// to result in steps set by the single read port of each store: accept with
// redirection lookup, protection fetch, target fetch, commit. The commit
// waits while the result register is still full; s_tready returns the cycle
// after the commit, so the block takes a new request only once the current
// one is committed.
// After reset the block sweeps both stores to 0xFF, one entry per cycle,
// over max(MEM_BYTES, 3*BITMAP_BYTES+REDIRECT_PAGES) entries, 8192 by default;
// s_tready stays low until then, while size_select writes are taken at any
// time. size_select must only be written with no request in flight.
`include "onewire_eprom_slave_macros.svh"

module onewire_eprom_slave #(
    parameter int unsigned MEM_BYTES      = 8192,
    parameter int unsigned REDIRECT_PAGES = 256,
    parameter int unsigned BITMAP_BYTES   = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // request channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] command
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [0] out_valid, [2:1] error_code
    // size_select register
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);
    import owep_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;
    logic       out_free;
    logic       out_load;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [2:0] m_tuser_reg;

    // result register frees up in the same cycle it is taken
    assign out_free = !m_tvalid_reg || m_tready;

    owep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    owep_dp #(
        .MEM_BYTES      (MEM_BYTES),
        .REDIRECT_PAGES (REDIRECT_PAGES),
        .BITMAP_BYTES   (BITMAP_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_slot     (s_tuser),
        .in_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= result.out_byte;
            m_tuser_reg <= {result.error_code, result.out_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A result is only committed while the sequencer is not accepting.
    `OWEP_ASSERT_IMPL(a_no_load_when_ready, aclk, aresetn, s_tready, !out_load)
    // An accepted request keeps the input closed in the following cycle.
    `OWEP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A driven byte never carries an error.
    `OWEP_ASSERT_IMPL(a_driven_no_error, aclk, aresetn, m_tvalid && m_tuser[0],
                      m_tuser[2:1] == ERR_NONE)

endmodule

// File: bench/onewire_eprom_slave_test.sv
// Self-checking bench for the one-wire EPROM slave: random and directed bus slots
// with a built-in predictor of the device. Depends on owep_pkg and onewire_eprom_slave.
module onewire_eprom_slave_test;
    timeunit 1ns;
    timeprecision 1ps;
    import owep_pkg::*;

    localparam int MEM_SZ = 8192;
    localparam int BMAP = 32;
    localparam int RPAGES = 256;
    localparam int WATCH_LIMIT = 40000;

    // device phases of the predictor
    typedef enum logic [4:0] {
        P_IDLE, P_ALO, P_AHI, P_DONE, P_RD, P_RCL, P_RCH,
        P_XR, P_XRCL, P_XRCH, P_XD, P_XDCL, P_XDCH,
        P_SD, P_SCL, P_SCH, P_WD, P_WCL, P_WCH, P_WRES
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } slot_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [7:0] s_tdata = 0;
    logic [1:0] s_tuser = 0;
    logic m_tvalid, m_tready = 0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_wr_data = 0;

    onewire_eprom_slave u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial forever #2 aclk = ~aclk;

    // predictor state
    logic [7:0] mem [MEM_SZ];
    logic [7:0] stat [3*BMAP+RPAGES];
    phase_t ph;
    logic [7:0] cur_cmd, held;
    logic [15:0] taddr, crc;
    logic [1:0] size_sel;

    slot_t pending[$];
    result_t answers[$];
    int errors = 0;
    int send_idle = 22, recv_idle = 86;
    bit recv_hold = 0;
    bit drain_req = 0;
    int quiet = 0;

    function automatic logic [15:0] size_bytes();
        case (size_sel)
            2'd0: return 256;
            2'd1: return 512;
            2'd2: return 2048;
            default: return 8192;
        endcase
    endfunction

    function automatic logic [15:0] crc_upd(logic [15:0] c, logic [7:0] b);
        logic [15:0] x;
        x = c;
        for (int i = 0; i < 8; i++) begin
            if (x[0] ^ b[i]) x = (x >> 1) ^ 16'hA001;
            else x = x >> 1;
        end
        return x;
    endfunction

    function automatic bit bit_clr(int base, int pg);
        if ((pg >> 3) >= BMAP) return 1;
        return stat[base + (pg >> 3)][pg & 7] == 1'b0;
    endfunction

    function automatic logic [7:0] redir(int pg);
        if (pg >= RPAGES) return 8'h00;
        return ~stat[3*BMAP + pg];
    endfunction

    function automatic logic [15:0] xlate(logic [15:0] a);
        logic [7:0] d;
        d = redir(a[12:5]);
        if (d == 0) return a;
        return {3'b0, d, a[4:0]};
    endfunction

    function automatic logic [7:0] mem_rd(logic [15:0] a);
        logic [15:0] d;
        d = xlate(a);
        return d < MEM_SZ ? mem[d] : 8'h00;
    endfunction

    function automatic logic [7:0] stat_rd(logic [15:0] a);
        if (a < 16'h020) return a < BMAP ? stat[a] : 8'h00;
        if (a < 16'h040) return (a - 16'h020) < BMAP ? stat[BMAP + a - 16'h020] : 8'h00;
        if (a < 16'h060) return (a - 16'h040) < BMAP ? stat[2*BMAP + a - 16'h040] : 8'h00;
        if (a < 16'h100) return 8'hFF;
        if (a < ST_END) return (a - 16'h100) < RPAGES ? stat[3*BMAP + a - 16'h100] : 8'hFF;
        return 8'hFF;
    endfunction

    function automatic logic [7:0] stat_wr(logic [15:0] a, logic [7:0] v);
        int s;
        if (a < 16'h020) begin
            if (a >= BMAP) return 8'h00;
            s = a;
        end else if (a < 16'h040) begin
            s = a - 16'h020;
            if (s >= BMAP) return 8'h00;
            s += BMAP;
        end else if (a < 16'h060) begin
            s = a - 16'h040;
            if (s >= BMAP) return 8'h00;
            s += 2*BMAP;
        end else if (a < 16'h100) begin
            return 8'hFF;
        end else if (a < ST_END) begin
            s = a - 16'h100;
            if (s >= RPAGES) return 8'hFF;
            if (bit_clr(BMAP, s & 255)) return 8'h00;
            s += 3*BMAP;
        end else begin
            return 8'hFF;
        end
        stat[s] &= v;
        return stat[s];
    endfunction

    function automatic logic [7:0] mem_wr(logic [15:0] a, logic [7:0] v);
        logic [15:0] d;
        int pg;
        d = xlate(a);
        pg = d[12:5];
        if (d >= MEM_SZ || bit_clr(0, pg)) return 8'h00;
        mem[d] &= v;
        if ((pg >> 3) < BMAP) stat[2*BMAP + (pg >> 3)][pg & 7] = 1'b0;
        return mem[d];
    endfunction

    function automatic bit known_cmd(logic [7:0] c);
        return c inside {CMD_READ_MEM, CMD_EXT_READ, CMD_READ_STATUS, CMD_WRITE_MEM,
                         CMD_SPEED_WR_MEM, CMD_WRITE_STATUS, CMD_SPEED_WR_STAT};
    endfunction

    function automatic bit is_mem_wr();
        return cur_cmd == CMD_WRITE_MEM || cur_cmd == CMD_SPEED_WR_MEM;
    endfunction

    function automatic bit wr_sends_crc();
        return cur_cmd == CMD_WRITE_MEM || cur_cmd == CMD_WRITE_STATUS;
    endfunction

    // Advance the device model by one slot and return its answer.
    function automatic result_t slot_answer(slot_t it);
        result_t r;
        logic [15:0] inv;
        logic [7:0] v;
        r = '{error_code: ERR_NONE, out_valid: 1'b0, out_byte: 8'hFF};
        inv = ~crc;
        if (it.cmd == SLOT_RESET) begin
            ph = P_IDLE;
        end else if (it.cmd == SLOT_WRITE) begin
            case (ph)
                P_IDLE: begin
                    cur_cmd = it.data; crc = crc_upd(16'h0, it.data); ph = P_ALO;
                end
                P_ALO: begin
                    taddr = {8'h0, it.data}; crc = crc_upd(crc, it.data); ph = P_AHI;
                end
                P_AHI: begin
                    taddr[15:8] = it.data;
                    crc = crc_upd(crc, it.data);
                    case (cur_cmd)
                        CMD_READ_MEM: ph = taddr < size_bytes() ? P_RD : P_RCL;
                        CMD_EXT_READ: ph = taddr < size_bytes() ? P_XR : P_DONE;
                        CMD_READ_STATUS: ph = taddr < ST_END ? P_SD : P_DONE;
                        CMD_WRITE_MEM, CMD_SPEED_WR_MEM:
                            ph = taddr < size_bytes() ? P_WD : P_DONE;
                        CMD_WRITE_STATUS, CMD_SPEED_WR_STAT:
                            ph = taddr < ST_END ? P_WD : P_DONE;
                        default: ph = P_DONE;
                    endcase
                    if (!known_cmd(cur_cmd)) r.error_code = ERR_UNKNOWN;
                end
                P_DONE: ;
                P_WD: begin
                    held = it.data;
                    if (cur_cmd != CMD_SPEED_WR_MEM) crc = crc_upd(crc, it.data);
                    ph = wr_sends_crc() ? P_WCL : P_WRES;
                end
                default: r.error_code = ERR_TURN;
            endcase
        end else if (it.cmd == SLOT_READ) begin
            r.out_valid = 1'b1;
            case (ph)
                P_RD: begin
                    v = mem_rd(taddr); crc = crc_upd(crc, v); taddr++;
                    if (taddr >= size_bytes()) ph = P_RCL;
                end
                P_RCL: begin v = inv[7:0]; ph = P_RCH; end
                P_RCH: begin v = inv[15:8]; ph = P_DONE; end
                P_XR: begin
                    v = redir(taddr[12:5]); crc = crc_upd(crc, v); ph = P_XRCL;
                end
                P_XRCL: begin v = inv[7:0]; ph = P_XRCH; end
                P_XRCH: begin v = inv[15:8]; crc = 0; ph = P_XD; end
                P_XD: begin
                    v = mem_rd(taddr); crc = crc_upd(crc, v); taddr++;
                    if (taddr[4:0] == 0) ph = P_XDCL;
                end
                P_XDCL: begin v = inv[7:0]; ph = P_XDCH; end
                P_XDCH: begin
                    v = inv[15:8]; crc = 0;
                    ph = taddr < size_bytes() ? P_XR : P_DONE;
                end
                P_SD: begin
                    v = stat_rd(taddr); crc = crc_upd(crc, v); taddr++;
                    if (taddr[2:0] == 0) ph = P_SCL;
                end
                P_SCL: begin v = inv[7:0]; ph = P_SCH; end
                P_SCH: begin
                    v = inv[15:8]; crc = 0;
                    ph = taddr < ST_END ? P_SD : P_DONE;
                end
                P_WCL: begin v = inv[7:0]; ph = P_WCH; end
                P_WCH: begin v = inv[15:8]; ph = P_WRES; end
                P_WRES: begin
                    v = is_mem_wr() ? mem_wr(taddr, held) : stat_wr(taddr, held);
                    taddr++;
                    if (wr_sends_crc()) crc = taddr;
                    ph = taddr < (is_mem_wr() ? size_bytes() : ST_END) ? P_WD : P_DONE;
                end
                default: begin
                    r.out_valid = 1'b0; v = 8'hFF;
                    if (ph != P_DONE) r.error_code = ERR_TURN;
                end
            endcase
            r.out_byte = v;
        end else begin
            r.error_code = ERR_TURN;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Request driver: pulls from the pending queue, idles at random.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                answers.push_back(slot_answer('{cmd: s_tuser, data: s_tdata}));
            end
            if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && !drain_req &&
                    $urandom_range(99) >= send_idle) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending[0].cmd;
                    s_tdata <= pending[0].data;
                    void'(pending.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = answers.pop_front();
                    if (m_tdata !== want.out_byte)
                        report_mismatch("out_byte", m_tdata, want.out_byte);
                    if (m_tuser[0] !== want.out_valid)
                        report_mismatch("out_valid", m_tuser[0], want.out_valid);
                    if (m_tuser[2:1] !== want.error_code)
                        report_mismatch("error_code", m_tuser[2:1], want.error_code);
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on handshake progress; the post-reset store sweep counts too.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT) begin
            $display("Timeout waiting for a handshake");
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push(logic [1:0] c, logic [7:0] d);
        pending.push_back('{cmd: c, data: d});
    endtask

    task automatic header(logic [7:0] c, logic [15:0] a);
        push(SLOT_RESET, $urandom);
        push(SLOT_WRITE, c);
        push(SLOT_WRITE, a[7:0]);
        push(SLOT_WRITE, a[15:8]);
    endtask

    // Wait until every queued request went out and every answer came back.
    // Checked on the falling edge so that the driver's updates have settled.
    task automatic drain();
        do @(negedge aclk);
        while (pending.size() > 0 || answers.size() > 0 || s_tvalid);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_size(logic [1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        size_sel = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] rand_addr(logic [7:0] c);
        logic [15:0] lim;
        lim = (c == CMD_READ_STATUS || c == CMD_WRITE_STATUS || c == CMD_SPEED_WR_STAT)
              ? ST_END : size_bytes();
        case ($urandom_range(9))
            0: return $urandom;                          // usually beyond end
            1: return lim - $urandom_range(1, 3);        // runs into the end
            default: return $urandom_range(lim - 1);
        endcase
    endfunction

    // One random transaction; its command may be unknown and noise slots may be mixed in.
    task automatic rand_txn();
        logic [7:0] c;
        int n;
        case ($urandom_range(7))
            0: c = CMD_READ_MEM;
            1: c = CMD_EXT_READ;
            2: c = CMD_READ_STATUS;
            3: c = CMD_WRITE_MEM;
            4: c = CMD_SPEED_WR_MEM;
            5: c = CMD_WRITE_STATUS;
            6: c = CMD_SPEED_WR_STAT;
            default: c = $urandom;
        endcase
        header(c, rand_addr(c));
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            if (c == CMD_WRITE_MEM || c == CMD_SPEED_WR_MEM ||
                c == CMD_WRITE_STATUS || c == CMD_SPEED_WR_STAT) begin
                // mostly clear few bits so stores don't saturate to zero
                push(SLOT_WRITE, $urandom_range(3) == 0 ? $urandom : ~(8'h1 << $urandom_range(7)));
                if (c == CMD_WRITE_MEM || c == CMD_WRITE_STATUS) begin
                    push(SLOT_READ, $urandom);
                    push(SLOT_READ, $urandom);
                end
                push(SLOT_READ, $urandom);
            end else begin
                push(SLOT_READ, $urandom);
            end
            if ($urandom_range(19) == 0) push($urandom_range(3), $urandom);  // noise
        end
    endtask

    initial begin
        int stall;
        foreach (mem[i]) mem[i] = 8'hFF;
        foreach (stat[i]) stat[i] = 8'hFF;
        ph = P_IDLE; cur_cmd = 0; taddr = 0; crc = 0; held = 0; size_sel = 2'd3;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: out-of-turn, command three, unknown command, memory write, memory reads.
        push(SLOT_READ, 8'h00);
        push(2'd3, 8'hFF);
        header(8'h00, 16'h0000);
        push(SLOT_READ, 8'h00);
        push(SLOT_WRITE, 8'hFF);
        header(CMD_WRITE_MEM, 16'h0000);
        push(SLOT_WRITE, 8'h00);
        push(SLOT_WRITE, 8'h12);                         // write during read slot turn
        push(SLOT_READ, 0); push(SLOT_READ, 0); push(SLOT_READ, 0);
        header(CMD_READ_MEM, 16'h1FFF);
        push(SLOT_READ, 0); push(SLOT_READ, 0); push(SLOT_READ, 0); push(SLOT_READ, 0);
        header(CMD_READ_MEM, 16'hFFFF);                  // start beyond end: CRC only
        push(SLOT_READ, 0); push(SLOT_READ, 0);
        drain();

        // Protect page 1 and redirect page 2 to page 5, then exercise both.
        header(CMD_WRITE_STATUS, 16'h0000);
        push(SLOT_WRITE, 8'hFD); push(SLOT_READ, 0); push(SLOT_READ, 0); push(SLOT_READ, 0);
        header(CMD_SPEED_WR_STAT, 16'h0102);
        push(SLOT_WRITE, 8'hFA); push(SLOT_READ, 0);
        header(CMD_SPEED_WR_MEM, 16'h0020);
        push(SLOT_WRITE, 8'h00); push(SLOT_READ, 0);
        header(CMD_EXT_READ, 16'h0040);
        repeat (4) push(SLOT_READ, 0);
        header(CMD_READ_STATUS, 16'h01FE);
        repeat (5) push(SLOT_READ, 0);
        drain();

        // Random phases across sizes and idle profiles.
        for (int phase_no = 0; phase_no < 6; phase_no++) begin
            set_size(phase_no == 0 ? 2'd0 : phase_no == 5 ? 2'd3 : $urandom_range(3));
            if (phase_no == 2) begin send_idle = 86; recv_idle = 22; end
            if (phase_no == 4) begin send_idle = 0; recv_idle = 0; end
            while (pending.size() < 250) rand_txn();
            if (phase_no == 1) begin
                // long receiver hold-off while requests keep coming
                recv_hold = 1;
                stall = 0;
                while (stall < 300) begin @(posedge aclk); stall++; end
                recv_hold = 0;
            end
            if (phase_no == 3) begin
                // sender pause until all answers are back
                while (pending.size() > 120) @(posedge aclk);
                drain_req = 1;
                do @(negedge aclk);
                while (answers.size() > 0 || s_tvalid);
                drain_req = 0;
            end
            drain();
        end

        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/owep_pkg.sv
sv/owep_ctrl.sv
sv/owep_dp.sv
sv/onewire_eprom_slave.sv
bench/onewire_eprom_slave_test.sv
